// File: rtl/rlas_pkg.sv
`timescale 1ns / 1ps
package rlas_pkg;

    localparam int LED_COUNT  = 13;
    localparam int CHAN_COUNT = LED_COUNT * 3;
    localparam int ADDR_W     = $clog2(CHAN_COUNT);

    localparam logic [11:0] FULL      = 12'hfff;
    localparam logic [11:0] STEP20    = 12'(4095 / 20);
    localparam logic [11:0] STEP50    = 12'(4095 / 50);
    localparam logic [11:0] DIM_GREEN = 12'h08f;

    localparam logic [6:0] DEV_ADDR0 = 7'b1000000;
    localparam logic [6:0] DEV_ADDR1 = 7'b1000001;
    localparam logic [6:0] DEV_ADDR2 = 7'b1000010;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_LED  = 2'd1;
    localparam logic [1:0] KIND_MODE = 2'd2;

    localparam logic [3:0] MODE_NONE     = 4'd0;
    localparam logic [3:0] MODE_ERROR    = 4'd1;
    localparam logic [3:0] MODE_TEST     = 4'd2;
    localparam logic [3:0] MODE_JOYSTICK = 4'd3;
    localparam logic [3:0] MODE_AUTO     = 4'd4;
    localparam logic [3:0] MODE_BALL_REQ = 4'd5;
    localparam logic [3:0] MODE_WAIT_REM = 4'd6;
    localparam logic [3:0] MODE_LOADED   = 4'd7;
    localparam logic [3:0] MODE_GOTO_ST  = 4'd8;
    localparam logic [3:0] MODE_GOTO_FIN = 4'd9;
    localparam logic [3:0] MODE_MAN_ST   = 4'd10;
    localparam logic [3:0] MODE_MAN_FIN  = 4'd11;
    localparam logic [3:0] MODE_STANDBY  = 4'd12;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  requested_mode;
        logic [3:0]  wall_bits;
        logic [3:0]  led_index;
        logic [15:0] red_level;
        logic [15:0] green_level;
        logic [15:0] blue_level;
    } t_in_req;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [3:0]  channel_number;
        logic [11:0] pwm_value;
        logic        outputs_enabled;
        logic        last_write;
    } t_out_req;

    typedef struct packed {
        logic [11:0] r;
        logic [11:0] g;
        logic [11:0] b;
    } t_rgb;

    // per led: mask_c wins over mask_b, then all_set, else keep stored value
    typedef struct packed {
        logic                 run;
        logic                 all_set;
        logic [LED_COUNT-1:0] mask_b;
        logic [LED_COUNT-1:0] mask_c;
        t_rgb                 col_a;
        t_rgb                 col_b;
        t_rgb                 col_c;
    } t_run;

    function automatic logic [6:0] led_dev_addr(input logic [3:0] led);
        logic [6:0] a;
        if (led < 4'd5) begin
            a = DEV_ADDR0;
        end else if (led < 4'd10) begin
            a = DEV_ADDR1;
        end else begin
            a = DEV_ADDR2;
        end
        return a;
    endfunction

    function automatic logic [3:0] led_chan0(input logic [3:0] led);
        logic [3:0] c;
        case (led)
            4'd0, 4'd5, 4'd11: c = 4'd0;
            4'd1, 4'd6, 4'd10: c = 4'd3;
            4'd2, 4'd7, 4'd12: c = 4'd6;
            4'd3, 4'd8:        c = 4'd9;
            default:           c = 4'd12;
        endcase
        return c;
    endfunction

    function automatic logic [11:0] rgb_pick(input t_rgb x, input logic [1:0] col);
        logic [11:0] v;
        case (col)
            2'd0:    v = x.r;
            2'd1:    v = x.g;
            default: v = x.b;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/rlas_colour_ram.sv
`timescale 1ns / 1ps
module rlas_colour_ram
    import rlas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [11:0]       i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [11:0]       o_rdata
);

    logic [11:0]           r_mem [CHAN_COUNT];
    logic [CHAN_COUNT-1:0] r_valid;
    logic [11:0]           r_rdata;
    logic                  r_rhit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rhit  <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rhit <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rhit ? r_rdata : 12'd0;

endmodule

// File: rtl/rlas_mode_ctrl.sv
`timescale 1ns / 1ps
module rlas_mode_ctrl
    import rlas_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_in_req i_req,
    output t_run    o_run,
    output logic    o_enable
);

    localparam t_rgb BLACK = '{r: 12'd0, g: 12'd0, b: 12'd0};
    localparam t_rgb RED   = '{r: FULL, g: 12'd0, b: 12'd0};
    localparam t_rgb GREEN = '{r: 12'd0, g: FULL, b: 12'd0};
    localparam t_rgb BLUE  = '{r: 12'd0, g: 12'd0, b: FULL};
    localparam logic [LED_COUNT-1:0] LEFT_MASK  = 13'h081f;
    localparam logic [LED_COUNT-1:0] RIGHT_MASK = 13'h07e0;
    localparam logic [LED_COUNT-1:0] ONE        = 13'd1;

    logic [6:0] r_cnt, n_cnt;
    logic [3:0] r_cur, n_cur;
    logic [3:0] r_pend, n_pend;
    logic       r_en, n_en;
    t_run       run;
    logic [6:0] n;
    logic [18:0] p20, p50, pdn;
    logic [11:0] v20, v50, vdn;
    logic [LED_COUNT-1:0] walls;

    always_comb begin
        n_cnt  = r_cnt;
        n_cur  = r_cur;
        n_pend = r_pend;
        n_en   = r_en;
        run    = '0;
        n      = r_cnt;
        if (r_pend != r_cur) begin
            n = 7'd0;
        end
        p20 = 19'(n) * 19'(STEP20);
        p50 = 19'(n) * 19'(STEP50);
        pdn = 19'(n - 7'd20) * 19'(STEP20);
        v20 = p20[11:0];
        v50 = p50[11:0];
        vdn = FULL - pdn[11:0];
        walls = '0;
        if (i_req.wall_bits[0]) walls = walls | 13'h0078;
        if (i_req.wall_bits[1]) walls = walls | 13'h03c0;
        if (i_req.wall_bits[2]) walls = walls | 13'h0e01;
        if (i_req.wall_bits[3]) walls = walls | 13'h000f;

        case (i_req.kind)
            KIND_TICK: begin
                if (r_pend != r_cur) begin
                    n_cur = r_pend;
                    n_en  = 1'b1;
                end
                run.run = 1'b1;
                case (n_cur)
                    MODE_ERROR: begin
                        run.run = 1'b0;
                        if (n == 7'd0) begin
                            run = '{run: 1'b1, all_set: 1'b1, col_a: RED, default: '0};
                            n = 7'd1;
                        end else if (n == 7'd5) begin
                            run = '{run: 1'b1, all_set: 1'b1, default: '0};
                            n = 7'd0;
                        end else begin
                            n = n + 7'd1;
                        end
                    end
                    MODE_TEST: begin
                        run.run = 1'b0;
                        run.all_set = 1'b1;
                        if (n == 7'd0) begin
                            run.run = 1'b1; run.col_a = RED;
                        end else if (n == 7'd20) begin
                            run.run = 1'b1; run.col_a = GREEN;
                        end else if (n == 7'd40) begin
                            run.run = 1'b1; run.col_a = BLUE;
                        end else if (n == 7'd60) begin
                            run.run = 1'b1; run.col_a = BLACK;
                        end
                        if (!run.run) run.all_set = 1'b0;
                        n = (n == 7'd80) ? 7'd0 : n + 7'd1;
                    end
                    MODE_JOYSTICK, MODE_AUTO, MODE_BALL_REQ, MODE_WAIT_REM,
                    MODE_LOADED: begin
                        if (n == 7'd0) begin
                            run.all_set = 1'b1;
                            n = 7'd1;
                        end else if ((n <= 7'd20) || (n_cur == MODE_WAIT_REM && n <= 7'd50)
                                     || (n_cur == MODE_LOADED && n <= 7'd40)) begin
                            run.all_set = 1'b1;
                            case (n_cur)
                                MODE_JOYSTICK: begin
                                    run.col_a  = '{r: v20, g: v20, b: 12'd0};
                                    run.mask_b = walls;
                                    run.col_b  = RED;
                                end
                                MODE_AUTO:     run.col_a = '{r: v20, g: v20, b: v20};
                                MODE_BALL_REQ: run.col_a = '{r: 12'd0, g: 12'd0, b: v20};
                                MODE_WAIT_REM: run.col_a = '{r: 12'd0, g: v50, b: 12'd0};
                                default: run.col_a = '{r: 12'd0, g: 12'd0,
                                                       b: (n <= 7'd20) ? v20 : vdn};
                            endcase
                            n = n + 7'd1;
                        end else begin
                            n = 7'd0;
                            if (n_cur == MODE_BALL_REQ) run.run = 1'b0;
                        end
                    end
                    MODE_GOTO_ST: begin
                        run.col_c = BLUE;
                        if (n == 7'd0) begin
                            run.all_set = 1'b1;
                            run.mask_c  = ONE;
                        end else if (n <= 7'd11) begin
                            run.mask_b = ONE << (n - 7'd1);
                            run.mask_c = ONE << n;
                        end else if (n == 7'd12) begin
                            run.mask_b = ONE << 11;
                            run.mask_c = ONE;
                            n = 7'd0;
                        end
                        n = n + 7'd1;
                    end
                    MODE_GOTO_FIN, MODE_MAN_ST, MODE_MAN_FIN: begin
                        if (n == 7'd0) begin
                            run.all_set = 1'b1;
                        end else if (n == 7'd5) begin
                            run.all_set = 1'b1;
                            if (n_cur == MODE_MAN_FIN) begin
                                run.col_a = BLUE;
                            end else begin
                                run.col_a  = RED;
                                run.mask_b = LEFT_MASK;
                                run.mask_c = RIGHT_MASK;
                                run.col_b  = (n_cur == MODE_GOTO_FIN) ? BLUE : GREEN;
                                run.col_c  = (n_cur == MODE_GOTO_FIN) ? GREEN : BLUE;
                            end
                        end else if (n == 7'd10) begin
                            run.all_set = 1'b1;
                            n = 7'd0;
                        end
                        n = n + 7'd1;
                    end
                    MODE_STANDBY: begin
                        run.run = 1'b0;
                        if (n == 7'd0) begin
                            run = '{run: 1'b1, all_set: 1'b1, default: '0};
                            run.col_a.g = DIM_GREEN;
                            n = 7'd1;
                        end
                    end
                    default: run.run = 1'b0;
                endcase
                n_cnt = n;
            end
            KIND_LED: begin
                run.run = 1'b1;
                if (i_req.led_index < 4'(LED_COUNT)) begin
                    run.mask_b = ONE << i_req.led_index;
                end
                run.col_b = '{r: i_req.red_level[11:0], g: i_req.green_level[11:0],
                              b: i_req.blue_level[11:0]};
            end
            KIND_MODE: begin
                if (i_req.requested_mode <= MODE_STANDBY) begin
                    run.run     = 1'b1;
                    run.all_set = 1'b1;
                    n_pend      = i_req.requested_mode;
                end
            end
            default: run = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_cur  <= MODE_NONE;
            r_pend <= MODE_NONE;
            r_en   <= 1'b0;
        end else if (i_accept) begin
            r_cnt  <= n_cnt;
            r_cur  <= n_cur;
            r_pend <= n_pend;
            r_en   <= n_en;
        end
    end

    assign o_run    = run;
    assign o_enable = r_en;

endmodule

// File: rtl/rgb_led_animation_sequencer_core.sv
`timescale 1ns / 1ps
// Animation engine for 13 RGB LEDs on three PWM controllers. A request that
// causes an update run is accepted, then the first colour entry is read, then
// one channel write is made per cycle while the output does not stall, each
// a read-modify-write through the single colour RAM. Requests that emit
// nothing leave the core idle for the next request. The colour store reads as
// zero after reset through per-entry valid flags, so no clearing pass is needed.
module rgb_led_animation_sequencer_core
    import rlas_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_WB} t_state;

    t_state            r_state;
    t_run              r_run;
    t_run              run;
    logic              enable;
    logic [3:0]        r_led;
    logic [1:0]        r_col;
    logic [ADDR_W-1:0] r_addr;
    logic              accept, can_load, last;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [11:0]       rdata, wdata;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign can_load   = !o_out_valid || !i_out_stall;
    assign last       = (r_led == 4'(LED_COUNT - 1)) && (r_col == 2'd2);

    rlas_mode_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_req),
        .o_run    (run),
        .o_enable (enable)
    );

    always_comb begin
        if (r_run.mask_c[r_led]) begin
            wdata = rgb_pick(r_run.col_c, r_col);
        end else if (r_run.mask_b[r_led]) begin
            wdata = rgb_pick(r_run.col_b, r_col);
        end else if (r_run.all_set) begin
            wdata = rgb_pick(r_run.col_a, r_col);
        end else begin
            wdata = rdata;
        end
    end

    assign ram_we    = (r_state == ST_WB) && can_load;
    assign ram_re    = (r_state == ST_RD) || (ram_we && !last);
    assign ram_raddr = (r_state == ST_RD) ? r_addr : r_addr + ADDR_W'(1);

    rlas_colour_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (ram_we) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_run  <= run;
                        r_led  <= 4'd0;
                        r_col  <= 2'd0;
                        r_addr <= '0;
                        if (run.run) begin
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    r_state <= ST_WB;
                end
                ST_WB: begin
                    if (can_load) begin
                        o_out_req.device_address    <= led_dev_addr(r_led);
                        o_out_req.channel_number    <= led_chan0(r_led) + 4'(r_col);
                        o_out_req.pwm_value         <= wdata;
                        o_out_req.outputs_enabled   <= enable;
                        o_out_req.last_write        <= last;
                        r_addr                      <= r_addr + ADDR_W'(1);
                        if (last) begin
                            r_state <= ST_IDLE;
                        end else if (r_col == 2'd2) begin
                            r_col <= 2'd0;
                            r_led <= r_led + 4'd1;
                        end else begin
                            r_col <= r_col + 2'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // last write of a run is always led 12 blue on the third controller
    a_last_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.last_write |->
            o_out_req.channel_number == 4'd8 && o_out_req.device_address == DEV_ADDR2)
        else $error("last write on wrong channel");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("stalled write changed");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WB |-> r_addr < ADDR_W'(CHAN_COUNT))
        else $error("colour address out of range");

    a_addr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WB |-> 6'(r_addr) == 6'(r_led) * 6'd3 + 6'(r_col))
        else $error("address out of step with led");

endmodule

// File: tb/sv/led_sequencer_checker.sv
`timescale 1ns / 1ps
module led_sequencer_checker
    import rlas_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_in_req  i_in_req,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_out_req i_out_req,
    output int       o_fail_count,
    output int       o_pending_writes
);

    logic [11:0] colours [CHAN_COUNT];
    logic [6:0]  steps;
    logic [3:0]  mode_now;
    logic [3:0]  mode_next;
    logic        enabled;
    t_out_req    write_queue [$];

    assign o_pending_writes = write_queue.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic void paint_led(input int led, input logic [15:0] r,
                                      input logic [15:0] g, input logic [15:0] b);
        if (led < LED_COUNT) begin
            colours[led*3]   = r[11:0];
            colours[led*3+1] = g[11:0];
            colours[led*3+2] = b[11:0];
        end
    endfunction

    function automatic void paint_all(input logic [11:0] r, input logic [11:0] g,
                                      input logic [11:0] b);
        for (int i = 0; i < LED_COUNT; i++) paint_led(i, r, g, b);
    endfunction

    function automatic void paint_split(input logic [11:0] lr, input logic [11:0] lg,
                                        input logic [11:0] lb, input logic [11:0] rr,
                                        input logic [11:0] rg, input logic [11:0] rb);
        paint_led(11, lr, lg, lb);
        for (int i = 0; i <= 4; i++) paint_led(i, lr, lg, lb);
        for (int i = 5; i <= 10; i++) paint_led(i, rr, rg, rb);
        paint_led(12, FULL, 0, 0);
    endfunction

    function automatic void queue_writes();
        t_out_req w;
        int k;
        int chan0 [LED_COUNT] = '{0, 3, 6, 9, 12, 0, 3, 6, 9, 12, 3, 0, 6};
        k = 0;
        for (int led = 0; led < LED_COUNT; led++) begin
            for (int c = 0; c < 3; c++) begin
                w.device_address  = led < 5 ? DEV_ADDR0 : (led < 10 ? DEV_ADDR1 : DEV_ADDR2);
                w.channel_number  = 4'(chan0[led] + c);
                w.pwm_value       = colours[led*3+c];
                w.outputs_enabled = enabled;
                w.last_write      = (k == CHAN_COUNT - 1);
                write_queue.push_back(w);
                k++;
            end
        end
    endfunction

    function automatic bit step_pattern(input logic [3:0] walls);
        int n;
        bit upd;
        logic [11:0] v;
        n = steps;
        upd = 1;
        case (mode_now)
            MODE_ERROR: begin
                upd = 0;
                if (n == 0) begin paint_all(FULL, 0, 0); upd = 1; n = 1; end
                else if (n == 5) begin paint_all(0, 0, 0); upd = 1; n = 0; end
                else n++;
            end
            MODE_TEST: begin
                upd = 0;
                if (n == 0) begin paint_all(FULL, 0, 0); upd = 1; n++; end
                else if (n == 20) begin paint_all(0, FULL, 0); upd = 1; n++; end
                else if (n == 40) begin paint_all(0, 0, FULL); upd = 1; n++; end
                else if (n == 60) begin paint_all(0, 0, 0); upd = 1; n++; end
                else if (n == 80) n = 0;
                else n++;
            end
            MODE_JOYSTICK: begin
                if (n == 0) begin paint_all(0, 0, 0); n = 1; end
                else if (n <= 20) begin
                    v = 12'(n * STEP20);
                    paint_all(v, v, 0);
                    if (walls[0]) for (int i = 3; i <= 6; i++) paint_led(i, FULL, 0, 0);
                    if (walls[1]) for (int i = 6; i <= 9; i++) paint_led(i, FULL, 0, 0);
                    if (walls[2]) begin
                        for (int i = 9; i <= 11; i++) paint_led(i, FULL, 0, 0);
                        paint_led(0, FULL, 0, 0);
                    end
                    if (walls[3]) for (int i = 0; i <= 3; i++) paint_led(i, FULL, 0, 0);
                    n++;
                end else n = 0;
            end
            MODE_AUTO: begin
                if (n == 0) begin paint_all(0, 0, 0); n = 1; end
                else if (n <= 20) begin v = 12'(n * STEP20); paint_all(v, v, v); n++; end
                else n = 0;
            end
            MODE_BALL_REQ: begin
                if (n == 0) begin paint_all(0, 0, 0); n = 1; end
                else if (n <= 20) begin paint_all(0, 0, 12'(n * STEP20)); n++; end
                else begin n = 0; upd = 0; end
            end
            MODE_WAIT_REM: begin
                if (n == 0) begin paint_all(0, 0, 0); n = 1; end
                else if (n <= 50) begin paint_all(0, 12'(n * STEP50), 0); n++; end
                else n = 0;
            end
            MODE_LOADED: begin
                if (n == 0) begin paint_all(0, 0, 0); n = 1; end
                else if (n <= 20) begin paint_all(0, 0, 12'(n * STEP20)); n++; end
                else if (n <= 40) begin
                    paint_all(0, 0, 12'(FULL - (n - 20) * STEP20));
                    n++;
                end else n = 0;
            end
            MODE_GOTO_ST: begin
                if (n == 0) begin paint_all(0, 0, 0); paint_led(0, 0, 0, FULL); end
                else if (n <= LED_COUNT - 2) begin
                    paint_led(n - 1, 0, 0, 0);
                    paint_led(n, 0, 0, FULL);
                end else if (n == LED_COUNT - 1) begin
                    paint_led(n - 1, 0, 0, 0);
                    paint_led(0, 0, 0, FULL);
                    n = 0;
                end
                n++;
            end
            MODE_GOTO_FIN, MODE_MAN_ST: begin
                if (n == 0) paint_all(0, 0, 0);
                else if (n == 5) begin
                    if (mode_now == MODE_GOTO_FIN) paint_split(0, 0, FULL, 0, FULL, 0);
                    else paint_split(0, FULL, 0, 0, 0, FULL);
                end else if (n == 10) begin paint_all(0, 0, 0); n = 0; end
                n++;
            end
            MODE_MAN_FIN: begin
                if (n == 0) paint_all(0, 0, 0);
                else if (n == 5) paint_all(0, 0, FULL);
                else if (n == 10) begin paint_all(0, 0, 0); n = 0; end
                n++;
            end
            MODE_STANDBY: begin
                upd = 0;
                if (n == 0) begin paint_all(0, DIM_GREEN, 0); upd = 1; n = 1; end
            end
            default: upd = 0;
        endcase
        steps = 7'(n);
        return upd;
    endfunction

    function automatic void predict_request(input t_in_req r);
        case (r.kind)
            KIND_TICK: begin
                if (mode_next != mode_now) begin
                    mode_now = mode_next;
                    enabled  = 1;
                    steps    = 0;
                end
                if (step_pattern(r.wall_bits)) queue_writes();
            end
            KIND_LED: begin
                paint_led(r.led_index, r.red_level, r.green_level, r.blue_level);
                queue_writes();
            end
            KIND_MODE: begin
                if (r.requested_mode <= MODE_STANDBY) begin
                    paint_all(0, 0, 0);
                    mode_next = r.requested_mode;
                    queue_writes();
                end
            end
            default: ;
        endcase
    endfunction

    initial begin
        o_fail_count = 0;
        foreach (colours[i]) colours[i] = 0;
        steps = 0;
        mode_now = MODE_NONE;
        mode_next = MODE_NONE;
        enabled = 0;
    end

    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && i_in_valid && !i_in_stall) predict_request(i_in_req);
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (write_queue.size() == 0) begin
                report_mismatch("unexpected write", i_out_req, 0);
            end else begin
                want = write_queue.pop_front();
                if (i_out_req.device_address != want.device_address)
                    report_mismatch("device_address", i_out_req.device_address,
                                    want.device_address);
                if (i_out_req.channel_number != want.channel_number)
                    report_mismatch("channel_number", i_out_req.channel_number,
                                    want.channel_number);
                if (i_out_req.pwm_value != want.pwm_value)
                    report_mismatch("pwm_value", i_out_req.pwm_value, want.pwm_value);
                if (i_out_req.outputs_enabled != want.outputs_enabled)
                    report_mismatch("outputs_enabled", i_out_req.outputs_enabled,
                                    want.outputs_enabled);
                if (i_out_req.last_write != want.last_write)
                    report_mismatch("last_write", i_out_req.last_write, want.last_write);
            end
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import rlas_pkg::*;

    logic     i_clk = 0;
    logic     i_rst_n = 0;
    logic     in_valid = 0;
    logic     in_stall;
    t_in_req  in_req = '0;
    logic     out_valid;
    logic     out_stall = 0;
    t_out_req out_req;
    int       fail_count;
    int       pending_writes;
    bit       hold_off = 0;
    bit       drain_phase = 0;

    always #5 i_clk = ~i_clk;

    rgb_led_animation_sequencer_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_req  (out_req)
    );

    led_sequencer_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_req        (in_req),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_req       (out_req),
        .o_fail_count    (fail_count),
        .o_pending_writes(pending_writes)
    );

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_in_req random_request();
        t_in_req r;
        int p;
        r = t_in_req'({$urandom, $urandom});
        p = $urandom_range(0, 99);
        if (p < 65) r.kind = KIND_TICK;
        else if (p < 82) r.kind = KIND_LED;
        else if (p < 97) begin
            r.kind = KIND_MODE;
            if ($urandom_range(0, 7) != 0) r.requested_mode = 4'($urandom_range(0, 12));
        end else r.kind = 2'd3;
        return r;
    endfunction

    task automatic send_request(input t_in_req r);
        int g;
        g = gap_length();
        if (g != 0) begin
            in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1;
        in_req   <= r;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    function automatic t_in_req make_request(input logic [1:0] k, input logic [3:0] m,
                                             input logic [3:0] w, input logic [3:0] led,
                                             input logic [15:0] r, input logic [15:0] g,
                                             input logic [15:0] b);
        t_in_req x;
        x.kind = k;
        x.requested_mode = m;
        x.wall_bits = w;
        x.led_index = led;
        x.red_level = r;
        x.green_level = g;
        x.blue_level = b;
        return x;
    endfunction

    always @(posedge i_clk) begin
        int g;
        if (hold_off) begin
            out_stall <= 1;
        end else if (drain_phase || $urandom_range(0, 9) < 6) begin
            out_stall <= 0;
        end else begin
            g = gap_length();
            out_stall <= (g != 0);
        end
    end

    initial begin
        int wait_count;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_request(make_request(KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_request(make_request(KIND_LED, 0, 0, 0, 16'hffff, 16'h0000, 16'hffff));
        send_request(make_request(KIND_LED, 0, 0, 12, 16'h0000, 16'hffff, 16'h0001));
        send_request(make_request(KIND_LED, 0, 0, 15, 16'h1234, 16'h5678, 16'h9abc));
        send_request(make_request(2'd3, 4'hf, 4'hf, 4'hf, 16'hffff, 16'hffff, 16'hffff));
        send_request(make_request(KIND_MODE, 4'd13, 0, 0, 0, 0, 0));
        send_request(make_request(KIND_MODE, 4'd15, 0, 0, 0, 0, 0));
        for (int m = 1; m <= 12; m++) begin
            send_request(make_request(KIND_MODE, 4'(m), 0, 0, 0, 0, 0));
            send_request(make_request(KIND_TICK, 0, 4'hf, 0, 0, 0, 0));
        end
        send_request(make_request(KIND_MODE, MODE_STANDBY, 0, 0, 0, 0, 0));
        send_request(make_request(KIND_TICK, 0, 4'h5, 0, 0, 0, 0));
        for (int i = 0; i < 220; i++) begin
            if (i == 60) begin
                in_valid <= 0;
                @(posedge i_clk);
                while (pending_writes != 0) @(posedge i_clk);
                repeat (50) @(posedge i_clk);
            end
            if (i == 100) send_request(make_request(KIND_MODE, MODE_JOYSTICK, 0, 0, 0, 0, 0));
            send_request(random_request());
        end
        in_valid <= 0;
        drain_phase = 1;
        wait_count = 0;
        @(posedge i_clk);
        while (pending_writes != 0 && wait_count < 20000) begin
            @(posedge i_clk);
            wait_count++;
        end
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending_writes == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (2000) @(posedge i_clk);
        hold_off = 1;
        repeat (400) @(posedge i_clk);
        hold_off = 0;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
rtl/rlas_pkg.sv
rtl/rlas_colour_ram.sv
rtl/rlas_mode_ctrl.sv
rtl/rgb_led_animation_sequencer_core.sv
tb/sv/led_sequencer_checker.sv
tb/sv/testbench.sv
